>>> rtl/lru_pkg.sv
// Package for the LRU page replacement block: field widths, stored-entry
// types and the sequencer state type. Depends on nothing.
`default_nettype none

package lru_pkg;

    localparam int LRU_MAX_FRAMES = 16;

    localparam int PID_W   = 8;
    localparam int PAGE_W  = 14;
    localparam int STAMP_W = 32;
    localparam int FAULT_W = 32;
    localparam int FIDX_W  = 4;
    localparam int CFG_W   = 5;

    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    typedef struct packed {
        logic [PID_W-1:0]  pid;
        logic [PAGE_W-1:0] page;
    } t_tag;

    typedef struct packed {
        t_tag               tag;
        logic [STAMP_W-1:0] stamp;
    } t_entry;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } t_state;

endpackage

`default_nettype wire

>>> rtl/lru_req_if.sv
// Request channel of the LRU page replacement block: one page reference
// per beat. Depends on lru_pkg.
`default_nettype none

interface lru_req_if import lru_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [PID_W-1:0]  process_id;
    logic [PAGE_W-1:0] page_number;

    modport source (output valid, output process_id, output page_number, input ready);
    modport sink   (input valid, input process_id, input page_number, output ready);
endinterface

`default_nettype wire

>>> rtl/lru_rsp_if.sv
// Response channel of the LRU page replacement block: one result per
// reference. Depends on lru_pkg.
`default_nettype none

interface lru_rsp_if import lru_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               hit;
    logic [FIDX_W-1:0]  frame_index;
    logic [FAULT_W-1:0] fault_count;

    modport source (output valid, output hit, output frame_index, output fault_count,
                    input ready);
    modport sink   (input valid, input hit, input frame_index, input fault_count,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/lru_scan.sv
// Shared compare unit of the LRU block: looks at one frame per beat of the
// scan and keeps first match, first empty frame and oldest stamp. Uses lru_pkg.
`default_nettype none

module lru_scan import lru_pkg::*; #(
    parameter int MAX_FRAMES = LRU_MAX_FRAMES
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic          i_cmp_vld,
    input  wire logic [((MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1)-1:0] i_cmp_idx,
    input  wire t_entry        i_entry,
    input  wire logic          i_entry_vld,
    input  wire t_tag          i_key,
    output logic               o_hit,
    output logic [((MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1)-1:0] o_slot
);

    localparam int IW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

    logic               r_found;
    logic               r_empty;
    logic [IW-1:0]      r_hit_slot;
    logic [IW-1:0]      r_empty_slot;
    logic [IW-1:0]      r_old_slot;
    logic [STAMP_W-1:0] r_old_stamp;

    logic match;
    logic older;
    logic first;

    assign match = i_entry_vld && (i_entry.tag == i_key);
    assign older = i_entry.stamp < r_old_stamp;
    assign first = (i_cmp_idx == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
            r_empty <= 1'b0;
        end else if (i_start) begin
            r_found <= 1'b0;
            r_empty <= 1'b0;
        end else if (i_cmp_vld) begin
            if (!r_found && match) begin
                r_found <= 1'b1;
            end
            if (!r_empty && !i_entry_vld) begin
                r_empty <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmp_vld) begin
            if (!r_found && match) begin
                r_hit_slot <= i_cmp_idx;
            end
            if (!r_empty && !i_entry_vld) begin
                r_empty_slot <= i_cmp_idx;
            end
            if (first || older) begin
                r_old_stamp <= i_entry.stamp;
                r_old_slot  <= i_cmp_idx;
            end
        end
    end

    always_comb begin
        o_hit = r_found;
        priority if (r_found) begin
            o_slot = r_hit_slot;
        end else if (r_empty) begin
            o_slot = r_empty_slot;
        end else begin
            o_slot = r_old_slot;
        end
    end

endmodule

`default_nettype wire

>>> rtl/lru_page_replacement.sv
// Top level of the LRU page replacement block: frame memory, valid bits,
// counters and the scan sequencer. Depends on lru_pkg, lru_req_if,
// lru_rsp_if and lru_scan.
//
//   Channel   Direction  Carries
//   i_req     in         process_id, page_number (one reference per beat)
//   o_rsp     out        hit, frame_index, fault_count (one result per beat)
//   i_cfg_*   in         frames_in_use, written with i_cfg_we
//
// A reference passes from acceptance to the next acceptance through these steps,
// where N is the active frame count: N memory reads, one per frame through the
// single read port, a step to finish the last compare, one update and the
// idle state in which the next beat is taken.
// Reset clears all valid bits, both counters and sets frames_in_use to 16.
// A result waits in the output register; only the update waits on o_rsp.ready.
`default_nettype none

module lru_page_replacement import lru_pkg::*; #(
    parameter int MAX_FRAMES = LRU_MAX_FRAMES
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [CFG_W-1:0] i_cfg_wdata,
    lru_req_if.sink               i_req,
    lru_rsp_if.source             o_rsp
);

    localparam int IW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int NW = $clog2(MAX_FRAMES + 1);

    t_state                r_state;
    t_state                n_state;
    logic [CFG_W-1:0]      r_cfg;
    logic [MAX_FRAMES-1:0] r_valid;
    t_entry                r_mem [MAX_FRAMES];
    t_entry                r_rd_data;
    t_tag                  r_key;
    logic [NW-1:0]         r_rd_cnt;
    logic                  r_cmp_vld;
    logic [IW-1:0]         r_cmp_idx;
    logic [STAMP_W-1:0]    r_use_cnt;
    logic [FAULT_W-1:0]    r_faults;
    logic                  r_out_vld;
    logic                  r_out_hit;
    logic [FIDX_W-1:0]     r_out_idx;
    logic [FAULT_W-1:0]    r_out_faults;

    logic [NW-1:0]      active_n;
    logic               start;
    logic               rd_en;
    logic               upd;
    logic               scan_hit;
    logic [IW-1:0]      scan_slot;
    logic [STAMP_W-1:0] n_use_cnt;
    logic [FAULT_W-1:0] n_faults;

    always_comb begin
        priority if (r_cfg == '0) begin
            active_n = NW'(1);
        end else if (32'(r_cfg) > 32'(MAX_FRAMES)) begin
            active_n = NW'(MAX_FRAMES);
        end else begin
            active_n = NW'(r_cfg);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        start       = 1'b0;
        rd_en       = 1'b0;
        upd         = 1'b0;
        i_req.ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid) begin
                    start   = 1'b1;
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_rd_cnt == active_n) begin
                    n_state = ST_UPDATE;
                end else begin
                    rd_en = 1'b1;
                end
            end
            ST_UPDATE: begin
                if (!r_out_vld || o_rsp.ready) begin
                    upd     = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            r_cfg <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_key <= '{pid: i_req.process_id, page: i_req.page_number};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_cnt  <= '0;
            r_cmp_vld <= 1'b0;
        end else begin
            r_cmp_vld <= rd_en;
            if (start) begin
                r_rd_cnt <= '0;
            end else if (rd_en) begin
                r_rd_cnt <= r_rd_cnt + NW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_cmp_idx <= r_rd_cnt[IW-1:0];
            r_rd_data <= r_mem[r_rd_cnt[IW-1:0]];
        end
    end

    lru_scan #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_cmp_vld   (r_cmp_vld),
        .i_cmp_idx   (r_cmp_idx),
        .i_entry     (r_rd_data),
        .i_entry_vld (r_valid[r_cmp_idx]),
        .i_key       (r_key),
        .o_hit       (scan_hit),
        .o_slot      (scan_slot)
    );

    assign n_use_cnt = (r_use_cnt == '1) ? r_use_cnt : r_use_cnt + STAMP_W'(1);
    assign n_faults  = (scan_hit || r_faults == '1) ? r_faults : r_faults + FAULT_W'(1);

    always_ff @(posedge i_clk) begin
        if (upd) begin
            r_mem[scan_slot] <= '{tag: r_key, stamp: n_use_cnt};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_use_cnt <= '0;
            r_faults  <= '0;
        end else if (upd) begin
            r_valid[scan_slot] <= 1'b1;
            r_use_cnt          <= n_use_cnt;
            r_faults           <= n_faults;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (upd) begin
            r_out_vld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (upd) begin
            r_out_hit    <= scan_hit;
            r_out_idx    <= FIDX_W'(scan_slot);
            r_out_faults <= n_faults;
        end
    end

    assign o_rsp.valid       = r_out_vld;
    assign o_rsp.hit         = r_out_hit;
    assign o_rsp.frame_index = r_out_idx;
    assign o_rsp.fault_count = r_out_faults;

endmodule

`default_nettype wire

>>> rtl/lru_checker.sv
// Port-level checks for the LRU page replacement block, attached to the top
// level by the bind statement at the end. Depends on lru_pkg.
`default_nettype none

module lru_checker import lru_pkg::*; (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               i_in_ready,
    input wire logic               i_out_valid,
    input wire logic               i_out_ready,
    input wire logic               i_out_hit,
    input wire logic [FIDX_W-1:0]  i_out_frame_index,
    input wire logic [FAULT_W-1:0] i_out_fault_count
);

    // A reference occupies the block, so no second beat follows at once.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request accepted in back-to-back cycles");

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_hit)
            && $stable(i_out_frame_index) && $stable(i_out_fault_count))
        else $error("stalled result beat changed");

    // A fault always counts itself.
    a_fault_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_hit |-> i_out_fault_count != '0)
        else $error("fault reported with zero fault count");

endmodule

bind lru_page_replacement lru_checker u_lru_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_req.valid),
    .i_in_ready        (i_req.ready),
    .i_out_valid       (o_rsp.valid),
    .i_out_ready       (o_rsp.ready),
    .i_out_hit         (o_rsp.hit),
    .i_out_frame_index (o_rsp.frame_index),
    .i_out_fault_count (o_rsp.fault_count)
);

`default_nettype wire
